// ===== hdl/bfwh_pkg.sv =====
// Shared types for the blocking FIFO with waiter handoff.
// Holds the transaction and result structs and the operation and status codes.
// Depends on nothing.
package bfwh_pkg;

  localparam int PAYLOAD_W = 32;
  localparam int ID_PORT_W = 4;
  localparam int COUNT_W   = 32;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef enum logic {
    ST_GRANTED = 1'b0,
    ST_FULL    = 1'b1
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [PAYLOAD_W-1:0] payload;
    logic [ID_PORT_W-1:0] requester;
  } bfwh_item_t;

  typedef struct packed {
    status_t              status;
    logic [ID_PORT_W-1:0] granted_to;
    logic [PAYLOAD_W-1:0] granted_word;
    logic [COUNT_W-1:0]   served_total;
  } bfwh_result_t;

endpackage

// ===== hdl/bfwh_front.sv =====
// Front end: accepts input transactions, decodes the operation and holds
// them in a two-entry queue for the back end. Depends on bfwh_pkg.
module bfwh_front import bfwh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [PAYLOAD_W-1:0] payload,
  input  logic [ID_PORT_W-1:0] requester,
  output logic                 item_valid,
  input  logic                 item_ready,
  output bfwh_item_t           item
);

  bfwh_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  bfwh_item_t decoded;

  always_comb begin
    decoded.op        = operation ? OP_GET : OP_PUT;
    decoded.payload   = payload;
    decoded.requester = requester;
  end

  assign in_ready   = (fill != 2'd2);
  assign item_valid = (fill != 2'd0);
  assign item       = slots[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/bfwh_back.sv =====
// Back end: executes put and get transactions against the shared ring and
// registers one result per grant or rejection. Depends on bfwh_pkg.
module bfwh_back import bfwh_pkg::*; #(
  parameter int RING_DEPTH      = 16,
  parameter int WORD_WIDTH      = 32,
  parameter int REQUESTER_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  bfwh_item_t   item,
  output logic         res_valid,
  input  logic         res_ready,
  output bfwh_result_t res
);

  localparam int ID_W = $clog2(REQUESTER_COUNT);
  localparam int EW   = (WORD_WIDTH > ID_W) ? WORD_WIDTH : ID_W;
  localparam int HW   = $clog2(RING_DEPTH);
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int TW   = CW + 1;

  logic [EW-1:0]      mem [RING_DEPTH];
  logic [EW-1:0]      rd_q;
  logic               byp;
  logic [EW-1:0]      byp_data;

  logic [HW-1:0]      head;
  logic [HW-1:0]      head_next;
  logic [HW-1:0]      head_inc;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               waiters;
  logic               waiters_next;
  logic [COUNT_W-1:0] served;
  logic [COUNT_W-1:0] served_next;

  logic               take;
  logic               is_get;
  logic               match;
  logic               full;
  logic               pop;
  logic               push;
  logic               reject;
  logic [WORD_WIDTH-1:0] word;
  logic [ID_W-1:0]    id;
  logic [TW-1:0]      tail_sum;
  logic [HW-1:0]      tail;
  logic [EW-1:0]      wr_data;
  logic [EW-1:0]      head_entry;
  bfwh_result_t       res_next;
  logic               res_valid_next;

  assign item_ready = !res_valid || res_ready;
  assign take       = item_valid && item_ready;
  assign is_get     = (item.op == OP_GET);
  assign word       = WORD_WIDTH'(item.payload);
  assign id         = ID_W'(item.requester);
  assign match      = (count != '0) && (is_get ? !waiters : waiters);
  assign full       = (count == CW'(RING_DEPTH));
  assign pop        = take && match;
  assign reject     = take && !match && full;
  assign push       = take && !match && !full;
  assign head_entry = byp ? byp_data : rd_q;
  assign wr_data    = is_get ? EW'(id) : EW'(word);

  always_comb begin
    head_inc = (head == HW'(RING_DEPTH - 1)) ? '0 : head + HW'(1);
    tail_sum = TW'(head) + TW'(count);
    if (tail_sum >= TW'(RING_DEPTH)) begin
      tail_sum = tail_sum - TW'(RING_DEPTH);
    end
    tail = HW'(tail_sum);
  end

  always_comb begin
    head_next    = pop ? head_inc : head;
    count_next   = count + CW'(push) - CW'(pop);
    waiters_next = (push && (count == '0)) ? is_get : waiters;
    served_next  = pop ? served + COUNT_W'(1) : served;
  end

  always_comb begin
    res_next.status       = ST_FULL;
    res_next.granted_to   = '0;
    res_next.granted_word = '0;
    res_next.served_total = served;
    if (pop) begin
      res_next.status       = ST_GRANTED;
      res_next.served_total = served_next;
      if (is_get) begin
        res_next.granted_to   = item.requester;
        res_next.granted_word = PAYLOAD_W'(head_entry[WORD_WIDTH-1:0]);
      end else begin
        res_next.granted_to   = ID_PORT_W'(head_entry[ID_W-1:0]);
        res_next.granted_word = PAYLOAD_W'(word);
      end
    end
  end

  always_comb begin
    if (pop || reject) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wr_data;
    end
    rd_q     <= mem[head_next];
    byp      <= push && (tail == head_next);
    byp_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (pop || reject) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      waiters   <= 1'b0;
      served    <= '0;
      res_valid <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      waiters   <= waiters_next;
      served    <= served_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

// ===== hdl/blocking_fifo_with_waiter_handoff_top.sv =====
// Top level of the blocking FIFO with waiter handoff.
// Instantiates bfwh_front and bfwh_back; depends on bfwh_pkg.
//
// A put hands its word to the oldest parked requester, or buffers it; a get
// takes the oldest buffered word, or parks its requester id. One ring of
// RING_DEPTH entries holds either words or ids, never both. Each grant gives
// one result with the running grant count; a put or get that must store into
// a full ring gives a result with status set and changes nothing. Buffering
// transactions give no result. The block takes one transaction per cycle while
// no result stalls: the back end handles one per cycle against a ring memory
// whose head entry is read ahead into a register, and a two-entry input queue
// and the result register let either side stall. A result is presented in
// the cycle after its transaction is taken, so it passes the input queue and
// the result register before it can be taken. No clearing pass follows reset.
module blocking_fifo_with_waiter_handoff_top import bfwh_pkg::*; #(
  parameter int RING_DEPTH      = 16,
  parameter int WORD_WIDTH      = 32,
  parameter int REQUESTER_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [PAYLOAD_W-1:0] payload,
  input  logic [ID_PORT_W-1:0] requester,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 status,
  output logic [ID_PORT_W-1:0] granted_to,
  output logic [PAYLOAD_W-1:0] granted_word,
  output logic [COUNT_W-1:0]   served_total
);

  logic         item_valid;
  logic         item_ready;
  bfwh_item_t   item;
  bfwh_result_t res;

  bfwh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .payload    (payload),
    .requester  (requester),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  bfwh_back #(
    .RING_DEPTH      (RING_DEPTH),
    .WORD_WIDTH      (WORD_WIDTH),
    .REQUESTER_COUNT (REQUESTER_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign status       = res.status;
  assign granted_to   = res.granted_to;
  assign granted_word = res.granted_word;
  assign served_total = res.served_total;

endmodule

// ===== test/tb_blocking_fifo_with_waiter_handoff_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for blocking_fifo_with_waiter_handoff_top.
// Drives put and get transactions, predicts every handoff and rejection from a
// shadow ring, and checks each result field. Depends on bfwh_pkg and the RTL.
module tb_blocking_fifo_with_waiter_handoff_top;
  import bfwh_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int ITEM_COUNT  = 1750;
  localparam int CYCLE_LIMIT = 200000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 operation = 1'b0;
  logic [PAYLOAD_W-1:0] payload = '0;
  logic [ID_PORT_W-1:0] requester = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 status;
  logic [ID_PORT_W-1:0] granted_to;
  logic [PAYLOAD_W-1:0] granted_word;
  logic [COUNT_W-1:0]   served_total;

  bfwh_item_t   pending_ops[$];
  bfwh_result_t grants_due[$];
  bfwh_result_t oldest_grant;
  int           queued_count = 0;
  int           accepted_count = 0;
  int           failures = 0;
  int           cycle_count = 0;
  logic         calm;

  logic [PAYLOAD_W-1:0] shadow_ring [RING_DEPTH];
  logic [3:0]           shadow_head = '0;
  logic [4:0]           shadow_count = '0;
  logic                 shadow_waiters = 1'b0;
  logic [COUNT_W-1:0]   shadow_served = '0;

  blocking_fifo_with_waiter_handoff_top #(
    .RING_DEPTH(RING_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .payload(payload),
    .requester(requester),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .granted_to(granted_to),
    .granted_word(granted_word),
    .served_total(served_total)
  );

  assign calm = (accepted_count >= 700) && (accepted_count < 1000);

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic queue_op(input op_t op, input logic [PAYLOAD_W-1:0] word,
                          input logic [ID_PORT_W-1:0] who);
    bfwh_item_t it;
    it.op        = op;
    it.payload   = word;
    it.requester = who;
    pending_ops.push_back(it);
    queued_count++;
  endtask

  task automatic predict_handoff(input bfwh_item_t it);
    bfwh_result_t r;
    logic         matched;
    logic [3:0]   tail;
    r       = '0;
    matched = (shadow_count != 0) && (shadow_waiters == (it.op == OP_PUT));
    if (matched) begin
      r.status = ST_GRANTED;
      if (it.op == OP_PUT) begin
        r.granted_to   = shadow_ring[shadow_head][ID_PORT_W-1:0];
        r.granted_word = it.payload;
      end else begin
        r.granted_to   = it.requester;
        r.granted_word = shadow_ring[shadow_head];
      end
      shadow_head   = shadow_head + 4'd1;
      shadow_count  = shadow_count - 5'd1;
      shadow_served = shadow_served + 32'd1;
      r.served_total = shadow_served;
      grants_due.push_back(r);
    end else if (shadow_count == RING_DEPTH) begin
      r.status       = ST_FULL;
      r.served_total = shadow_served;
      grants_due.push_back(r);
    end else begin
      if (shadow_count == 0) shadow_waiters = (it.op == OP_GET);
      tail = shadow_head + shadow_count[3:0];
      shadow_ring[tail] = (it.op == OP_PUT) ? it.payload
                                            : {{(PAYLOAD_W-ID_PORT_W){1'b0}}, it.requester};
      shadow_count = shadow_count + 5'd1;
    end
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_handoff('{op: op_t'(operation), payload: payload, requester: requester});
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
          in_valid  <= 1'b1;
          operation <= pending_ops[0].op;
          payload   <= pending_ops[0].payload;
          requester <= pending_ops[0].requester;
          void'(pending_ops.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 38);
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %b %h %h %h", $time,
                   status, granted_to, granted_word, served_total);
          failures++;
        end else begin
          oldest_grant = grants_due.pop_front();
          check_field("status", 32'(oldest_grant.status), 32'(status));
          check_field("granted_to", 32'(oldest_grant.granted_to), 32'(granted_to));
          check_field("granted_word", oldest_grant.granted_word, granted_word);
          check_field("served_total", oldest_grant.served_total, served_total);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("blocking_fifo_with_waiter_handoff_top regression: fail");
    $finish;
  end

  initial begin
    int                   run_len;
    int                   put_pct;
    logic [PAYLOAD_W-1:0] word;
    // A get parks a requester, then a put with an all-ones word serves it.
    queue_op(OP_GET, $urandom, 4'd5);
    queue_op(OP_PUT, 32'hFFFF_FFFF, 4'($urandom_range(0, 15)));
    // A zero word is buffered, then taken by the highest requester id.
    queue_op(OP_PUT, 32'h0000_0000, 4'($urandom_range(0, 15)));
    queue_op(OP_GET, $urandom, 4'd15);
    // The mode flips back to waiters once the ring has drained.
    queue_op(OP_GET, 32'hFFFF_FFFF, 4'd0);
    queue_op(OP_GET, 32'h0000_0000, 4'd15);
    queue_op(OP_PUT, 32'hA5A5_A5A5, 4'd0);
    queue_op(OP_PUT, 32'h5A5A_5A5A, 4'd15);
    // Fill the ring with words; the extra put is rejected as ring full.
    for (int i = 0; i <= RING_DEPTH; i++) begin
      queue_op(OP_PUT, (i == 0) ? 32'h0 : $urandom, 4'($urandom_range(0, 15)));
    end

    while (queued_count < ITEM_COUNT) begin
      run_len = $urandom_range(4, 40);
      case ($urandom_range(0, 2))
        0:       put_pct = 85;
        1:       put_pct = 50;
        default: put_pct = 15;
      endcase
      for (int i = 0; i < run_len; i++) begin
        case ($urandom_range(0, 9))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom;
        endcase
        queue_op(($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET, word,
                 4'($urandom_range(0, 15)));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < queued_count) @(posedge clk);
    while (grants_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("blocking_fifo_with_waiter_handoff_top regression: pass");
    end else begin
      $display("blocking_fifo_with_waiter_handoff_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bfwh_pkg.sv
hdl/bfwh_front.sv
hdl/bfwh_back.sv
hdl/blocking_fifo_with_waiter_handoff_top.sv
test/tb_blocking_fifo_with_waiter_handoff_top.sv
